// ----- sv/rbe_pkg.sv -----
package rbe_pkg;

    // Item kinds on the input channel
    localparam logic FUNC_PIXEL = 1'b0;
    localparam logic FUNC_DRAIN = 1'b1;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_BORDER_COLOR = 2'd0,
        CFG_BACK_COLOR   = 2'd1,
        CFG_IMAGE_WIDTH  = 2'd2,
        CFG_IMAGE_HEIGHT = 2'd3
    } t_cfg_reg;

    localparam int          CFG_DIM_W         = 11;
    localparam logic [31:0] BORDER_COLOR_RST  = 32'h0000_00FF;
    localparam logic [31:0] BACK_COLOR_RST    = 32'hFFFF_FFFF;
    localparam logic [10:0] IMAGE_DIM_RST     = 11'd1024;

    // Control for the item sitting in the window stage
    typedef struct packed {
        logic valid;
        logic pixel;
        logic emit;
        logic edge_px;
        logic last;
    } t_s1_ctl;

    // One result item
    typedef struct packed {
        logic [31:0] color;
        logic        last;
    } t_result;

endpackage

// ----- sv/rbe_ram.sv -----
module rbe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/rbe_window.sv -----
module rbe_window import rbe_pkg::*; (
    input  logic        i_clk,
    input  t_s1_ctl     i_ctl,
    input  logic [31:0] i_up,
    input  logic [31:0] i_mid,
    input  logic [31:0] i_pix,
    input  logic [31:0] i_border_color,
    input  logic [31:0] i_back_color,
    output logic        o_push,
    output t_result     o_result
);

    logic [31:0] r_win [9];
    logic [31:0] n_win [9];
    logic        differs;

    // Shift the 3x3 window one column left and load the new right column
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_win[r*3]     = r_win[r*3 + 1];
            n_win[r*3 + 1] = r_win[r*3 + 2];
        end
        n_win[2] = i_up;
        n_win[5] = i_mid;
        n_win[8] = i_pix;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.valid && i_ctl.pixel) begin
            r_win <= n_win;
        end
    end

    // Any neighbour unlike the centre; a drain sees the window as it stands
    always_comb begin
        differs = 1'b0;
        for (int k = 0; k < 9; k++) begin
            if (k != 4) begin
                if (i_ctl.pixel) begin
                    if (n_win[k] != n_win[4]) differs = 1'b1;
                end else begin
                    if (r_win[k] != r_win[4]) differs = 1'b1;
                end
            end
        end
    end

    assign o_push          = i_ctl.valid && i_ctl.emit;
    assign o_result.color  = (i_ctl.edge_px || differs) ? i_border_color : i_back_color;
    assign o_result.last   = i_ctl.last;

endmodule

// ----- sv/rbe_out_fifo.sv -----
module rbe_out_fifo import rbe_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_result    i_data,
    input  logic       i_pop,
    output logic       o_valid,
    output t_result    o_data,
    output logic [1:0] o_count
);

    t_result    r_q [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       pop_ok;

    assign pop_ok = i_pop && (r_count != 2'd0);

    // Two-entry skid queue in front of the result port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) r_wr_ptr <= ~r_wr_ptr;
            if (pop_ok) r_rd_ptr <= ~r_rd_ptr;
            r_count <= r_count + 2'(i_push) - 2'(pop_ok);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr_ptr] <= i_data;
        end
    end

    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_q[r_rd_ptr];
    assign o_count = r_count;

endmodule

// ----- sv/region_boundary_extract_3x3_unit.sv -----
// The result for a pixel leaves image_width+1 items after that pixel; inside the datapath the
// releasing item is registered into the window stage and its result then into the result queue.
// Throughput: one item per cycle, but o_in_ready drops while the result queue is backed up.
// Reset (i_rst_n, synchronous): counters, queue and configuration go to their reset
// values at once; line stores and window are not cleared, so no start-up pass is needed.
module region_boundary_extract_3x3_unit import rbe_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input items
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_func,
    input  logic [31:0] i_pixel_color,
    // result items
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_out_color,
    output logic        o_last_of_frame,
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int W_W    = $clog2(MAX_WIDTH + 1);
    localparam int H_W    = $clog2(MAX_HEIGHT + 1);
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int PEND_W = $clog2(MAX_WIDTH + 3);

    // Configuration
    logic [31:0]          r_border_color;
    logic [31:0]          r_back_color;
    logic [CFG_DIM_W-1:0] r_image_width;
    logic [CFG_DIM_W-1:0] r_image_height;

    // Input-side position and output-side position
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic [COL_W-1:0]  r_ox;
    logic [ROW_W-1:0]  r_oy;
    logic [PEND_W-1:0] r_pending;

    // Window stage
    t_s1_ctl           r_s1;
    logic [31:0]       r_s1_pix;
    logic [COL_W-1:0]  r_s1_addr;
    logic              r_fwd;
    logic [31:0]       r_fwd_up;
    logic [31:0]       r_fwd_mid;

    logic              accept;
    logic              cfg_wr;
    logic              geom_wr;
    logic              pop;
    logic [1:0]        q_count;
    logic [2:0]        occ;
    logic [31:0]       w_sel;
    logic [31:0]       h_sel;
    logic [W_W-1:0]    w_eff;
    logic [H_W-1:0]    h_eff;
    logic [W_W-1:0]    w_m1;
    logic [H_W-1:0]    h_m1;
    logic              is_drain;
    logic              drain_ok;
    logic [PEND_W-1:0] pend_inc;
    logic              emit_px;
    logic              emit;
    logic              ox_end;
    logic              oy_end;
    logic              col_end;
    logic              row_end;
    logic [31:0]       up_q;
    logic [31:0]       mid_q;
    logic [31:0]       eff_up;
    logic [31:0]       eff_mid;
    logic              store_we;
    logic              push;
    t_result           res;
    t_result           q_head;
    t_s1_ctl           n_s1;

    assign accept  = i_in_valid && o_in_ready;
    assign cfg_wr  = i_cfg_valid && o_cfg_ready;
    assign geom_wr = cfg_wr && ((t_cfg_reg'(i_cfg_index) == CFG_IMAGE_WIDTH) ||
                                (t_cfg_reg'(i_cfg_index) == CFG_IMAGE_HEIGHT));
    assign o_cfg_ready = 1'b1;

    // Room check: queued results plus one that may still come out of the window stage
    assign pop        = o_out_valid && i_out_ready;
    assign occ        = 3'(q_count) + 3'(r_s1.valid);
    assign o_in_ready = (occ <= 3'd1) || ((occ == 3'd2) && pop);

    // Effective geometry: zero reads as one, large values saturate
    always_comb begin
        if (r_image_width == '0) begin
            w_sel = 32'd1;
        end else if (32'(r_image_width) > 32'(MAX_WIDTH)) begin
            w_sel = 32'(MAX_WIDTH);
        end else begin
            w_sel = 32'(r_image_width);
        end
        if (r_image_height == '0) begin
            h_sel = 32'd1;
        end else if (32'(r_image_height) > 32'(MAX_HEIGHT)) begin
            h_sel = 32'(MAX_HEIGHT);
        end else begin
            h_sel = 32'(r_image_height);
        end
    end

    assign w_eff = w_sel[W_W-1:0];
    assign h_eff = h_sel[H_W-1:0];
    assign w_m1  = w_eff - 1'b1;
    assign h_m1  = h_eff - 1'b1;

    // Emission decision, taken at the transfer
    assign is_drain = (i_func == FUNC_DRAIN);
    assign drain_ok = (r_pending != '0) && (r_col == '0) && (r_row == '0);
    assign pend_inc = r_pending + 1'b1;
    assign emit_px  = pend_inc > (PEND_W'(w_eff) + 1'b1);
    assign emit     = is_drain ? drain_ok : emit_px;

    assign col_end = (W_W'(r_col) == w_m1);
    assign row_end = (H_W'(r_row) == h_m1);
    assign ox_end  = (W_W'(r_ox) == w_m1);
    assign oy_end  = (H_W'(r_oy) == h_m1);

    always_comb begin
        n_s1         = '0;
        n_s1.valid   = accept;
        n_s1.pixel   = !is_drain;
        n_s1.emit    = emit;
        n_s1.edge_px = (r_ox == '0) || ox_end || (r_oy == '0) || oy_end;
        n_s1.last    = ox_end && oy_end;
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_border_color <= BORDER_COLOR_RST;
            r_back_color   <= BACK_COLOR_RST;
            r_image_width  <= IMAGE_DIM_RST;
            r_image_height <= IMAGE_DIM_RST;
        end else if (cfg_wr) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_BORDER_COLOR: r_border_color <= i_cfg_data;
                CFG_BACK_COLOR:   r_back_color   <= i_cfg_data;
                CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data[CFG_DIM_W-1:0];
                CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_data[CFG_DIM_W-1:0];
            endcase
        end
    end

    // Frame counters; a geometry write restarts the frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || geom_wr) begin
            r_col     <= '0;
            r_row     <= '0;
            r_ox      <= '0;
            r_oy      <= '0;
            r_pending <= '0;
        end else if (accept) begin
            if (!is_drain) begin
                if (col_end) begin
                    r_col <= '0;
                    r_row <= row_end ? '0 : r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
                r_pending <= emit_px ? r_pending : pend_inc;
            end else if (drain_ok) begin
                r_pending <= r_pending - 1'b1;
            end
            if (emit) begin
                if (ox_end) begin
                    r_ox <= '0;
                    r_oy <= oy_end ? '0 : r_oy + 1'b1;
                end else begin
                    r_ox <= r_ox + 1'b1;
                end
            end
        end
    end

    // Window stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1  <= '0;
            r_fwd <= 1'b0;
        end else begin
            r_s1  <= n_s1;
            r_fwd <= accept && !is_drain && r_s1.valid && r_s1.pixel && (r_s1_addr == r_col);
        end
    end

    // Stage payload and write-through data for a store read that meets its own write
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pix  <= i_pixel_color;
            r_s1_addr <= r_col;
            r_fwd_up  <= eff_mid;
            r_fwd_mid <= r_s1_pix;
        end
    end

    // Line stores: read at transfer, rotated in the cycle after
    assign store_we = r_s1.valid && r_s1.pixel;
    assign eff_up   = r_fwd ? r_fwd_up  : up_q;
    assign eff_mid  = r_fwd ? r_fwd_mid : mid_q;

    rbe_ram #(
        .WIDTH (32),
        .DEPTH (MAX_WIDTH)
    ) u_store_upper (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (r_s1_addr),
        .i_wdata (eff_mid),
        .i_re    (accept),
        .i_raddr (r_col),
        .o_rdata (up_q)
    );

    rbe_ram #(
        .WIDTH (32),
        .DEPTH (MAX_WIDTH)
    ) u_store_middle (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (r_s1_addr),
        .i_wdata (r_s1_pix),
        .i_re    (accept),
        .i_raddr (r_col),
        .o_rdata (mid_q)
    );

    // Window and neighbour compare
    rbe_window u_window (
        .i_clk          (i_clk),
        .i_ctl          (r_s1),
        .i_up           (eff_up),
        .i_mid          (eff_mid),
        .i_pix          (r_s1_pix),
        .i_border_color (r_border_color),
        .i_back_color   (r_back_color),
        .o_push         (push),
        .o_result       (res)
    );

    // Result queue
    rbe_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (res),
        .i_pop   (pop),
        .o_valid (o_out_valid),
        .o_data  (q_head),
        .o_count (q_count)
    );

    assign o_out_color     = q_head.color;
    assign o_last_of_frame = q_head.last;

    // Pending results never exceed one row plus one
    a_pending_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= (PEND_W'(w_eff) + 1'b1))
        else $error("pending count above width+1");

    // Input column stays inside the row
    a_col_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        W_W'(r_col) < w_eff)
        else $error("input column out of range");

    // The result queue is never pushed while full unless it is popped in the same cycle
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> ((q_count != 2'd2) || pop))
        else $error("result queue overflow");

    // Write-through is only armed by a pixel transfer
    a_fwd_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd |-> (r_s1.valid && r_s1.pixel))
        else $error("write-through without a pixel in the window stage");

endmodule
